/* rtl/sprite_clip_playback_sequencer_core_defines.svh */
// Assertion macros for the sprite clip playback sequencer.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SPRITE_CLIP_PLAYBACK_SEQUENCER_CORE_DEFINES_SVH
`define SPRITE_CLIP_PLAYBACK_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define SPCLIP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPCLIP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/spclip_pkg.sv */
// Shared types and constants for the sprite clip playback sequencer.
// No dependencies; imported by every module of the block.
package spclip_pkg;

	localparam int MAX_STEPS  = 64;
	localparam int MAX_CELLS  = 4096;
	localparam int STEP_W     = 6;
	localparam int CNT_W      = 7;
	localparam int CELL_W     = 12;
	localparam int CCNT_W     = 13;
	localparam int DUR_W      = 16;
	localparam int DELTA_W    = 24;
	localparam int ACC_W      = 25;
	localparam int FRAC_W     = 8;
	localparam int OP_W       = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_PLAY   = 3'd1;
	localparam logic [OP_W-1:0] OP_PAUSE  = 3'd2;
	localparam logic [OP_W-1:0] OP_SINGLE = 3'd3;
	localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;
	localparam logic [OP_W-1:0] OP_SEEK   = 3'd6;

	localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [DELTA_W-1:0] time_delta;
		logic [STEP_W-1:0]  entry_index;
		logic [CELL_W-1:0]  entry_cell;
		logic [DUR_W-1:0]   entry_duration;
	} in_item_t;

	typedef struct packed {
		logic [STEP_W-1:0] current_step;
		logic [CELL_W-1:0] shown_cell;
		logic              cell_valid;
		logic              selection_update;
		logic              is_playing;
	} out_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_no;
		logic [DUR_W-1:0]  duration;
	} step_entry_t;

	typedef struct packed {
		logic              wr_en;
		logic [STEP_W-1:0] wr_addr;
		step_entry_t       wr_entry;
		logic              rd_en;
		logic [STEP_W-1:0] rd_addr;
	} tbl_req_t;

endpackage

/* rtl/spclip_step_table.sv */
// Clip step table: one write port, one registered read port.
// Depends on spclip_pkg.
module spclip_step_table import spclip_pkg::*; (
	input  logic        clk,
	input  tbl_req_t    req,
	output step_entry_t rd_entry
);

	step_entry_t mem [MAX_STEPS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_entry;
		end
		// read data holds while no read is issued
		if (req.rd_en) begin
			rd_entry <= mem[req.rd_addr];
		end
	end

endmodule

/* rtl/sprite_clip_playback_sequencer_core.sv */
// Sprite clip playback sequencer, top level.
// Non-tick transactions pass EXEC, CELL and OUT into the output register; the next accept waits for IDLE.
// Tick while playing adds TICK passes, one per duration check (steps passed, plus one unless
// the clip ends in stop or reset mode); the table walks one step per cycle.
// Output register frees the input side while a result waits.
// Reset clears registers, position, time and run flag; the step table is not cleared.
module sprite_clip_playback_sequencer_core import spclip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "sprite_clip_playback_sequencer_core_defines.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_TICK = 3'd2;
	localparam logic [2:0] ST_CELL = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]        state_q, state_d;
	in_item_t          item_q;
	logic [MODE_W-1:0] loop_mode_q;
	logic [CNT_W-1:0]  step_count_q;
	logic [CCNT_W-1:0] cell_count_q;
	logic [STEP_W-1:0] pos_q, pos_d, start_q, start_d;
	logic [ACC_W-1:0]  acc_q, acc_d;
	logic              running_q, run_d;
	logic              event_q, event_d;
	logic              out_valid_q, load_out;
	out_item_t         out_item_q, out_item_d;

	tbl_req_t          tbl_req;
	step_entry_t       rd_entry;

	logic [CNT_W-1:0]  clip_len, pos_inc;
	logic              clip_empty, at_last, mode_stop, mode_reset;
	logic [STEP_W-1:0] last_idx, pos_clamp, cell_addr;
	logic [ACC_W:0]    acc_sum;
	logic [ACC_W-1:0]  acc_sat, need;
	logic [DUR_W-1:0]  dur_eff;
	logic              enough, cells_ok;
	logic [CCNT_W-1:0] cell_max;

	spclip_step_table u_table (
		.clk      (clk),
		.req      (tbl_req),
		.rd_entry (rd_entry)
	);

	assign clip_len   = (step_count_q > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : step_count_q;
	assign clip_empty = (clip_len == '0);
	assign last_idx   = STEP_W'(clip_len - CNT_W'(1));
	assign pos_inc    = {1'b0, pos_q} + CNT_W'(1);
	assign at_last    = (pos_inc >= clip_len);
	assign mode_stop  = (loop_mode_q == MODE_STOP);
	assign mode_reset = (loop_mode_q == MODE_RESET);
	assign pos_clamp  = (pos_q > last_idx) ? last_idx : pos_q;
	assign cell_addr  = clip_empty ? '0 : pos_clamp;

	// saturating time add
	assign acc_sum = {1'b0, acc_q} + (ACC_W+1)'(item_q.time_delta);
	assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

	// a zero duration counts as 1 ms
	assign dur_eff = (rd_entry.duration == '0) ? DUR_W'(1) : rd_entry.duration;
	assign need    = {1'b0, dur_eff, {FRAC_W{1'b0}}};
	assign enough  = (acc_q >= need);

	always_comb begin
		state_d   = state_q;
		pos_d     = pos_q;
		acc_d     = acc_q;
		run_d     = running_q;
		start_d   = start_q;
		event_d   = event_q;
		load_out  = 1'b0;
		tbl_req   = '0;
		tbl_req.wr_addr  = item_q.entry_index;
		tbl_req.wr_entry = '{cell_no: item_q.entry_cell, duration: item_q.entry_duration};
		tbl_req.rd_addr  = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					event_d = 1'b0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_CELL;
				unique case (item_q.operation)
					OP_TICK: begin
						if (running_q && !clip_empty) begin
							acc_d           = acc_sat;
							pos_d           = pos_clamp;
							start_d         = pos_clamp;
							tbl_req.rd_en   = 1'b1;
							tbl_req.rd_addr = pos_clamp;
							state_d         = ST_TICK;
						end
					end
					OP_PLAY: begin
						// stopped clip sitting at its end restarts
						if (!running_q && mode_stop && (clip_empty || pos_q >= last_idx) &&
						    acc_q == '0) begin
							pos_d = '0;
						end
						run_d   = 1'b1;
						event_d = 1'b1;
					end
					OP_PAUSE: run_d = 1'b0;
					OP_SINGLE: begin
						if (!clip_empty) begin
							run_d   = 1'b0;
							acc_d   = '0;
							event_d = 1'b1;
							if (!at_last) begin
								pos_d = pos_inc[STEP_W-1:0];
							end else if (!mode_stop) begin
								pos_d = '0;
							end
						end
					end
					OP_REWIND: begin
						if (!clip_empty) begin
							pos_d   = '0;
							acc_d   = '0;
							event_d = 1'b1;
						end
					end
					OP_WRITE: tbl_req.wr_en = 1'b1;
					OP_SEEK: begin
						if (!clip_empty) begin
							pos_d   = ({1'b0, item_q.entry_index} < clip_len) ?
							          item_q.entry_index : last_idx;
							acc_d   = '0;
							run_d   = 1'b0;
							event_d = 1'b1;
						end
					end
					default: ;
				endcase
			end
			ST_TICK: begin
				// rd_entry holds the duration of step pos_q
				if (!enough) begin
					event_d = (pos_q != start_q);
					state_d = ST_CELL;
				end else begin
					acc_d = acc_q - need;
					if (!at_last) begin
						pos_d           = pos_inc[STEP_W-1:0];
						tbl_req.rd_en   = 1'b1;
						tbl_req.rd_addr = pos_inc[STEP_W-1:0];
					end else if (mode_stop) begin
						run_d   = 1'b0;
						acc_d   = '0;
						event_d = (pos_q != start_q);
						state_d = ST_CELL;
					end else if (mode_reset) begin
						pos_d   = '0;
						run_d   = 1'b0;
						acc_d   = '0;
						event_d = (start_q != '0);
						state_d = ST_CELL;
					end else begin
						pos_d           = '0;
						tbl_req.rd_en   = 1'b1;
						tbl_req.rd_addr = '0;
					end
				end
			end
			ST_CELL: begin
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_addr = cell_addr;
				state_d         = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result assembly from the cell read
	assign cells_ok = !clip_empty && (cell_count_q != '0);
	assign cell_max = (cell_count_q > CCNT_W'(MAX_CELLS)) ? CCNT_W'(MAX_CELLS - 1) :
	                  cell_count_q - CCNT_W'(1);

	always_comb begin
		out_item_d                  = '0;
		out_item_d.current_step     = pos_q;
		out_item_d.cell_valid       = cells_ok;
		out_item_d.selection_update = event_q && cells_ok;
		out_item_d.is_playing       = running_q;
		if (cells_ok) begin
			out_item_d.shown_cell = ({1'b0, rd_entry.cell_no} > cell_max) ?
			                        cell_max[CELL_W-1:0] : rd_entry.cell_no;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			loop_mode_q  <= '0;
			step_count_q <= '0;
			cell_count_q <= '0;
			pos_q        <= '0;
			acc_q        <= '0;
			running_q    <= 1'b0;
			start_q      <= '0;
			event_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			pos_q     <= pos_d;
			acc_q     <= acc_d;
			running_q <= run_d;
			start_q   <= start_d;
			event_q   <= event_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LOOP_MODE:  loop_mode_q  <= cfg_data[MODE_W-1:0];
					CFG_STEP_COUNT: step_count_q <= cfg_data[CNT_W-1:0];
					CFG_CELL_COUNT: cell_count_q <= cfg_data[CCNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
		end
		if (load_out) begin
			out_item_q <= out_item_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`SPCLIP_ASSERT_NOW(a_tick_needs_run, state_q == ST_TICK, running_q && !clip_empty, "tick walk while paused or empty clip")
	`SPCLIP_ASSERT_NOW(a_tick_pos_in_clip, state_q == ST_TICK, pos_q <= last_idx, "tick walk position beyond clip")
	`SPCLIP_ASSERT_NOW(a_sel_needs_valid, out_valid && out_item.selection_update, out_item.cell_valid, "selection update without valid cell")
	`SPCLIP_ASSERT_NEXT(a_result_waits, state_q == ST_OUT && out_valid_q && !out_ready, state_q == ST_OUT, "result overwrote a pending transaction")

endmodule

/* dv/tb_sprite_clip_playback_sequencer_core.sv */
// Testbench for sprite_clip_playback_sequencer_core: directed clip scenarios, then random phases.
// A scoreboard class predicts each result; needs only spclip_pkg and the core.
`timescale 1ns / 100ps

module tb_sprite_clip_playback_sequencer_core import spclip_pkg::*; ();

	localparam logic [OP_W-1:0]   OP_UNUSED     = 3'd7;
	localparam logic [MODE_W-1:0] MODE_LOOP_ALT = 2'd3;
	localparam int unsigned       ACC_MAX       = (1 << ACC_W) - 1;

	class clip_playback_predictor;
		logic [CELL_W-1:0] cells [MAX_STEPS];
		logic [DUR_W-1:0]  durs [MAX_STEPS];
		logic [STEP_W-1:0] pos;
		int unsigned       acc;
		bit                running;
		logic [MODE_W-1:0] lmode;
		logic [CNT_W-1:0]  steps;
		logic [CCNT_W-1:0] ncells;
		out_item_t         expected_frames [$];
		int                errors;

		function new();
			pos = '0;
			acc = 0;
			running = 1'b0;
			lmode = MODE_STOP;
			steps = '0;
			ncells = '0;
			errors = 0;
		endfunction

		function int unsigned clip_len();
			return (steps < MAX_STEPS) ? steps : MAX_STEPS;
		endfunction

		// shortest step time in the clip, fixed point; clip must be non-empty
		function int unsigned min_need();
			int unsigned lo;
			int unsigned d;
			lo = 32'hFFFF_FFFF;
			for (int i = 0; i < clip_len(); i++) begin
				d = (durs[i] == '0) ? 1 : durs[i];
				if (d < lo)
					lo = d;
			end
			return lo << FRAC_W;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LOOP_MODE: lmode = data[MODE_W-1:0];
				CFG_STEP_COUNT: steps = data[CNT_W-1:0];
				CFG_CELL_COUNT: ncells = data[CCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_input(in_item_t it);
			int unsigned n;
			int unsigned nc;
			int unsigned start;
			int unsigned need;
			int unsigned s;
			bit moved;
			out_item_t r;
			n = clip_len();
			nc = (ncells < MAX_CELLS) ? ncells : MAX_CELLS;
			moved = 1'b0;
			case (it.operation)
				OP_TICK: begin
					if (running && n != 0) begin
						acc = acc + it.time_delta;
						if (acc > ACC_MAX)
							acc = ACC_MAX;
						if (pos > n - 1)
							pos = n - 1;
						start = pos;
						while (running) begin
							need = (durs[pos] == '0) ? 1 : int'(durs[pos]);
							need = need << FRAC_W;
							if (acc < need)
								break;
							acc = acc - need;
							if (pos + 1 < n) begin
								pos = pos + 1;
							end else if (lmode == MODE_STOP) begin
								pos = n - 1;
								running = 1'b0;
								acc = 0;
							end else if (lmode == MODE_RESET) begin
								pos = '0;
								running = 1'b0;
								acc = 0;
							end else begin
								pos = '0;
							end
						end
						moved = (pos != start);
					end
				end
				OP_PLAY: begin
					// stop-mode clip parked at its end restarts, only from pause
					if (!running && lmode == MODE_STOP && (n == 0 || pos >= n - 1) && acc == 0)
						pos = '0;
					running = 1'b1;
					moved = 1'b1;
				end
				OP_PAUSE: running = 1'b0;
				OP_SINGLE: begin
					if (n != 0) begin
						running = 1'b0;
						acc = 0;
						if (pos + 1 < n)
							pos = pos + 1;
						else if (lmode != MODE_STOP)
							pos = '0;
						moved = 1'b1;
					end
				end
				OP_REWIND: begin
					if (n != 0) begin
						pos = '0;
						acc = 0;
						moved = 1'b1;
					end
				end
				OP_WRITE: begin
					cells[it.entry_index] = it.entry_cell;
					durs[it.entry_index] = it.entry_duration;
				end
				OP_SEEK: begin
					if (n != 0) begin
						pos = (it.entry_index < n) ? it.entry_index : n - 1;
						acc = 0;
						running = 1'b0;
						moved = 1'b1;
					end
				end
				default: ;
			endcase
			r.current_step = pos;
			r.cell_valid = (n != 0 && nc != 0);
			r.shown_cell = '0;
			if (r.cell_valid) begin
				s = (pos < n) ? pos : n - 1;
				r.shown_cell = (cells[s] > nc - 1) ? nc - 1 : cells[s];
			end
			r.selection_update = moved && r.cell_valid;
			r.is_playing = running;
			expected_frames = {expected_frames, r};
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_frames.size() == 0) begin
				$error("result transaction with nothing pending");
				errors++;
				return;
			end
			want = expected_frames.pop_front();
			if (got.current_step !== want.current_step) begin
				$error("current_step: expected %0d, got %0d", want.current_step, got.current_step);
				errors++;
			end
			if (got.shown_cell !== want.shown_cell) begin
				$error("shown_cell: expected %0d, got %0d", want.shown_cell, got.shown_cell);
				errors++;
			end
			if (got.cell_valid !== want.cell_valid) begin
				$error("cell_valid: expected %0b, got %0b", want.cell_valid, got.cell_valid);
				errors++;
			end
			if (got.selection_update !== want.selection_update) begin
				$error("selection_update: expected %0b, got %0b",
					want.selection_update, got.selection_update);
				errors++;
			end
			if (got.is_playing !== want.is_playing) begin
				$error("is_playing: expected %0b, got %0b", want.is_playing, got.is_playing);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  quiet;

	clip_playback_predictor book;

	sprite_clip_playback_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				book.check_result(out_item);
			out_ready <= quiet || ($urandom_range(0, 99) >= 18);
		end
	end

	function automatic in_item_t item(logic [OP_W-1:0] op, int unsigned delta,
			int unsigned idx, int unsigned cell_no, int unsigned dur);
		in_item_t it;
		it.operation = op;
		it.time_delta = DELTA_W'(delta);
		it.entry_index = STEP_W'(idx);
		it.entry_cell = CELL_W'(cell_no);
		it.entry_duration = DUR_W'(dur);
		return it;
	endfunction

	// Mostly play-then-tick traffic; tick sizes are bounded by 64 times the shortest
	// step so one tick never walks an absurd number of steps.
	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned r;
		int unsigned sub;
		int unsigned delta;
		int unsigned cap;
		it = item(OP_TICK, $urandom, $urandom, $urandom, $urandom);
		r = $urandom_range(0, 99);
		if (!book.running && $urandom_range(0, 99) < 30)
			it.operation = OP_PLAY;
		else if (r < 55)
			it.operation = OP_TICK;
		else if (r < 65)
			it.operation = OP_PLAY;
		else if (r < 71)
			it.operation = OP_PAUSE;
		else if (r < 78)
			it.operation = OP_SINGLE;
		else if (r < 83)
			it.operation = OP_REWIND;
		else if (r < 91)
			it.operation = OP_WRITE;
		else if (r < 98)
			it.operation = OP_SEEK;
		else
			it.operation = OP_UNUSED;

		if (it.operation == OP_TICK && book.running && book.clip_len() != 0) begin
			cap = book.min_need() * 64;
			sub = $urandom_range(0, 99);
			if (sub < 60)
				delta = $urandom_range(0, 64 << FRAC_W);
			else if (sub < 92)
				delta = $urandom_range(0, 2000 << FRAC_W);
			else
				delta = $urandom_range(0, (1 << DELTA_W) - 1);
			if (delta > cap)
				delta = $urandom_range(0, cap);
			it.time_delta = delta;
		end
		if (it.operation == OP_WRITE) begin
			sub = $urandom_range(0, 99);
			if (sub < 15)
				it.entry_duration = $urandom_range(0, 4);
			else if (sub >= 25)
				it.entry_duration = $urandom_range(20, 3000);
		end
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 18) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		book.note_input(it);
	endtask

	// hold the input side until every pending result is back
	task automatic settle();
		in_valid <= 1'b0;
		while (book.expected_frames.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_registers(logic [MODE_W-1:0] mode, int unsigned nsteps,
			int unsigned ncell);
		logic [CFG_IDX_W-1:0]  regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		regs = '{CFG_LOOP_MODE, CFG_STEP_COUNT, CFG_CELL_COUNT};
		vals = '{CFG_DATA_W'(mode), CFG_DATA_W'(nsteps), CFG_DATA_W'(ncell)};
		settle();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			book.set_register(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#100_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int unsigned nsteps;
		int unsigned ncell;
		logic [MODE_W-1:0] mode;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		out_ready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_LOOP_MODE;
		cfg_data <= '0;
		quiet <= 1'b0;
		book = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the whole table while the clip is empty, so no read ever hits an unwritten entry
		for (int i = 0; i < MAX_STEPS; i++) begin
			case (i)
				0: send_item(item(OP_WRITE, 0, i, 0, 0));
				1: send_item(item(OP_WRITE, 0, i, 4095, 1));
				2: send_item(item(OP_WRITE, 0, i, 3, 65535));
				3: send_item(item(OP_WRITE, 0, i, 1, 2));
				default: send_item(item(OP_WRITE, $urandom, i, $urandom_range(0, 4095),
					$urandom_range(20, 3000)));
			endcase
		end

		// empty clip: everything but play, pause and write is ignored
		send_item(item(OP_TICK, 24'hFFFFFF, 0, 0, 0));
		send_item(item(OP_PLAY, 0, 0, 0, 0));
		send_item(item(OP_SINGLE, 0, 0, 0, 0));
		send_item(item(OP_REWIND, 0, 0, 0, 0));
		send_item(item(OP_SEEK, 0, 5, 0, 0));
		send_item(item(OP_PAUSE, 0, 0, 0, 0));

		// stop mode, four steps, cells clamp below three
		write_registers(MODE_STOP, 4, 3);
		send_item(item(OP_PLAY, 0, 0, 0, 0));
		send_item(item(OP_TICK, 24'hFFFFFF, 0, 0, 0));
		send_item(item(OP_TICK, 24'hFFFFFF, 0, 0, 0));
		send_item(item(OP_PLAY, 0, 0, 0, 0));
		send_item(item(OP_PLAY, 0, 0, 0, 0));
		send_item(item(OP_TICK, 0, 0, 0, 0));
		send_item(item(OP_SEEK, 0, 63, 0, 0));
		send_item(item(OP_SINGLE, 0, 0, 0, 0));
		send_item(item(OP_REWIND, 0, 0, 0, 0));
		send_item(item(OP_SINGLE, 0, 0, 0, 0));
		send_item(item(OP_PAUSE, 0, 0, 0, 0));
		send_item(item(OP_TICK, 24'h00FFFF, 0, 0, 0));
		send_item(item(OP_UNUSED, 0, 0, 0, 0));

		// mode three acts as loop; counts above the maximum clamp
		write_registers(MODE_LOOP_ALT, 127, 8191);
		send_item(item(OP_PLAY, 0, 0, 0, 0));
		send_item(item(OP_TICK, 24'hFFFFFF, 0, 0, 0));
		send_item(item(OP_SEEK, 0, 63, 0, 0));
		send_item(item(OP_SINGLE, 0, 0, 0, 0));
		send_item(item(OP_TICK, 24'h000100, 0, 0, 0));

		// reset mode: end of clip returns to step 0 and pauses
		write_registers(MODE_RESET, 2, 1);
		send_item(item(OP_PLAY, 0, 0, 0, 0));
		send_item(item(OP_TICK, 24'h000300, 0, 0, 0));

		for (int phase = 0; phase < 13; phase++) begin
			mode = (phase < 8) ? MODE_W'(phase % 4) : MODE_W'($urandom_range(0, 3));
			case (phase)
				0: nsteps = 1;
				1: nsteps = 2;
				2: nsteps = 64;
				3: nsteps = 127;
				4: nsteps = 0;
				default: nsteps = $urandom_range(1, 127);
			endcase
			case (phase)
				0: ncell = 4096;
				1: ncell = 1;
				2: ncell = 8191;
				3: ncell = 0;
				4: ncell = 4095;
				5: ncell = 2;
				default: ncell = $urandom_range(1, 8191);
			endcase
			write_registers(mode, nsteps, ncell);
			quiet <= (phase == 6);
			send_item(item(OP_REWIND, $urandom, $urandom, $urandom, $urandom));
			send_item(item(OP_PLAY, $urandom, $urandom, $urandom, $urandom));
			repeat (105)
				send_item(random_item());
		end

		settle();
		if (book.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/spclip_pkg.sv
rtl/spclip_step_table.sv
rtl/sprite_clip_playback_sequencer_core.sv
dv/tb_sprite_clip_playback_sequencer_core.sv
